FILE: sv/cftc_pkg.sv
// Package for the CRC-32 frame trailer check unit: beat and result types,
// frame constants, and the byte-wide CRC and hex digit helper functions.
// No dependencies.
package cftc_pkg;

  localparam int unsigned ByteW            = 8;
  localparam int unsigned CrcW             = 32;
  localparam int unsigned PlenW            = 9;
  localparam int unsigned TailLen          = 9;
  localparam int unsigned HexDigits        = 8;
  localparam int unsigned MinFrame         = 11;
  localparam int unsigned MaxFrameBytesDef = 512;

  localparam logic [CrcW-1:0]  CrcInit  = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]  CrcPoly  = 32'hEDB8_8320;
  localparam logic [ByteW-1:0] StarChar = 8'h2A;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_TOO_LONG = 2'd1,
    FAULT_CRC     = 2'd2
  } fault_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             frame_valid;
    fault_e           fault_kind;
    logic [CrcW-1:0]  decoded_crc;
    logic [CrcW-1:0]  computed_crc;
    logic [PlenW-1:0] payload_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic logic [CrcW-1:0] crc32_byte(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic hex_t hex_decode(logic [ByteW-1:0] c);
    hex_t h;
    logic [ByteW-1:0] diff;
    h.ok    = 1'b0;
    h.value = 4'd0;
    diff    = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff    = c - 8'h30;
      h.ok    = 1'b1;
      h.value = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff    = c - 8'h37;
      h.ok    = 1'b1;
      h.value = diff[3:0];
    end
    return h;
  endfunction

endpackage

FILE: sv/cftc_if.sv
// Valid/ready channel interfaces for the frame byte input and the result output.
// Depends on cftc_pkg.
interface cftc_in_if import cftc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cftc_out_if import cftc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             frame_valid;
  logic [1:0]       fault_kind;
  logic [CrcW-1:0]  decoded_crc;
  logic [CrcW-1:0]  computed_crc;
  logic [PlenW-1:0] payload_length;

  modport source (output valid, output frame_valid, output fault_kind, output decoded_crc,
                  output computed_crc, output payload_length, input ready);
  modport sink (input valid, input frame_valid, input fault_kind, input decoded_crc,
                input computed_crc, input payload_length, output ready);
endinterface

FILE: sv/crc32_frame_trailer_check_unit.sv
// Top level of the CRC-32 frame trailer check unit.
// Depends on cftc_pkg, the channel interfaces, cftc_in_reg, cftc_checker and cftc_out_reg.
//
// Frame bytes arrive on in_i, one per beat, with last_byte set on the final
// byte. The frame is a payload, a '*' and eight uppercase hex digits giving
// the reflected CRC-32 of the payload. For each final byte one result beat
// leaves on out_o; other bytes give no result.
// A final byte is captured in the input register; the checker stage then
// loads its result into the result register, which drives out_o, once
// that register is free. Throughput: one byte per cycle, except that a
// final byte waits while the result register is full. The byte-wide CRC
// step and the trailer decode sit in one stage between those two registers.
// Reset clears the input and result valid flags, the CRC accumulator, the
// tail line and the byte count; the block then takes bytes at once.
// The state returns to its reset values after each final byte.
// When the receiver holds out_o.ready low, the pending result stays put.
// Ordinary bytes keep flowing; a further final byte waits in the input
// register, and in_i.ready drops until the result register frees up.
module crc32_frame_trailer_check_unit import cftc_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cftc_in_if.sink    in_i,
  cftc_out_if.source out_o
);

  in_beat_t beat;
  logic     beat_valid;
  logic     advance;
  logic     load;
  logic     out_free;
  result_t  result;

  cftc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .beat_o    (beat),
    .valid_o   (beat_valid)
  );

  cftc_checker #(
    .MaxFrameBytes (MaxFrameBytes)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .valid_i    (beat_valid),
    .out_free_i (out_free),
    .advance_o  (advance),
    .load_o     (load),
    .result_o   (result)
  );

  cftc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .result_i   (result),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

FILE: sv/cftc_in_reg.sv
// Input register stage: captures one byte beat from the input channel.
// Depends on cftc_pkg and cftc_in_if.
module cftc_in_reg import cftc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cftc_in_if.sink   in_i,
  input  logic      advance_i,
  output in_beat_t  beat_o,
  output logic      valid_o
);

  logic     valid_q;
  in_beat_t beat_q;
  logic     accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.data_byte <= in_i.data_byte;
      beat_q.last_byte <= in_i.last_byte;
    end
  end

  assign beat_o  = beat_q;
  assign valid_o = valid_q;

endmodule

FILE: sv/cftc_checker.sv
// Frame state and trailer evaluation: CRC accumulator, nine-byte tail line,
// saturating byte count, and the combinational result for the final byte.
// Depends on cftc_pkg.
module cftc_checker import cftc_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_beat_t beat_i,
  input  logic     valid_i,
  input  logic     out_free_i,
  output logic     advance_o,
  output logic     load_o,
  output result_t  result_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] tail_q [TailLen];
  logic [ByteW-1:0] tail_d [TailLen];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CrcW-1:0]  calc;
  logic [CrcW-1:0]  rx;
  logic             digits_ok;
  hex_t             hex [HexDigits];

  assign advance_o = valid_i && (!beat_i.last_byte || out_free_i);
  assign load_o    = advance_o && beat_i.last_byte;

  always_comb begin
    crc_d = (cnt_q >= CntW'(TailLen)) ? crc32_byte(crc_q, tail_q[TailLen-1]) : crc_q;
    tail_d[0] = beat_i.data_byte;
    for (int i = 1; i < TailLen; i++) begin
      tail_d[i] = tail_q[i-1];
    end
    cnt_d = (cnt_q < CntW'(MaxFrameBytes)) ? cnt_q + 1'b1 : cnt_q;
  end

  always_comb begin
    digits_ok = 1'b1;
    rx        = '0;
    for (int i = 0; i < HexDigits; i++) begin
      hex[i]    = hex_decode(tail_d[HexDigits-1-i]);
      digits_ok = digits_ok && hex[i].ok;
      rx        = {rx[CrcW-5:0], hex[i].value};
    end
    calc = crc_d ^ CrcInit;

    result_o.frame_valid    = 1'b0;
    result_o.fault_kind     = FAULT_NONE;
    result_o.decoded_crc    = '0;
    result_o.computed_crc   = '0;
    result_o.payload_length = '0;
    priority if (cnt_d >= CntW'(MaxFrameBytes)) begin
      result_o.fault_kind = FAULT_TOO_LONG;
    end else if (cnt_d < CntW'(MinFrame)) begin
      result_o.fault_kind = FAULT_CRC;
    end else begin
      result_o.computed_crc   = calc;
      result_o.payload_length = PlenW'(cnt_d - CntW'(TailLen));
      if (tail_d[TailLen-1] != StarChar || !digits_ok) begin
        result_o.fault_kind = FAULT_CRC;
      end else begin
        result_o.decoded_crc = rx;
        if (rx != calc) begin
          result_o.fault_kind = FAULT_CRC;
        end else begin
          result_o.frame_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
      cnt_q <= '0;
      for (int i = 0; i < TailLen; i++) begin
        tail_q[i] <= '0;
      end
    end else if (load_o) begin
      crc_q <= CrcInit;
      cnt_q <= '0;
      for (int i = 0; i < TailLen; i++) begin
        tail_q[i] <= '0;
      end
    end else if (advance_o) begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      for (int i = 0; i < TailLen; i++) begin
        tail_q[i] <= tail_d[i];
      end
    end
  end

endmodule

FILE: sv/cftc_out_reg.sv
// Result register: holds one result beat until the output channel takes it.
// Depends on cftc_pkg and cftc_out_if.
module cftc_out_reg import cftc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    result_i,
  output logic       out_free_o,
  cftc_out_if.source out_o
);

  logic    valid_q;
  result_t result_q;

  assign out_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.frame_valid    = result_q.frame_valid;
  assign out_o.fault_kind     = result_q.fault_kind;
  assign out_o.decoded_crc    = result_q.decoded_crc;
  assign out_o.computed_crc   = result_q.computed_crc;
  assign out_o.payload_length = result_q.payload_length;

endmodule

FILE: sv/cftc_port_checker.sv
// Port-level assertions for the CRC-32 frame trailer check unit, and the bind
// that attaches them to the top level. Depends on cftc_pkg.
module cftc_port_checker import cftc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input logic             frame_valid,
  input logic [1:0]       fault_kind,
  input logic [CrcW-1:0]  decoded_crc,
  input logic [CrcW-1:0]  computed_crc,
  input logic [PlenW-1:0] payload_length
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("Result beat shown during reset.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(fault_kind)
      && $stable(decoded_crc) && $stable(computed_crc) && $stable(payload_length))
    else $error("Stalled result beat changed.");

  a_pass_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_valid |-> fault_kind == FAULT_NONE && decoded_crc == computed_crc)
    else $error("Passing frame with a fault or a CRC mismatch.");

  a_fail_has_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !frame_valid |-> fault_kind == FAULT_TOO_LONG || fault_kind == FAULT_CRC)
    else $error("Failing frame without a fault code.");

  a_too_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fault_kind == FAULT_TOO_LONG |->
      decoded_crc == '0 && computed_crc == '0 && payload_length == '0)
    else $error("Overlong frame result carries data.");

endmodule

bind crc32_frame_trailer_check_unit cftc_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .frame_valid    (out_o.frame_valid),
  .fault_kind     (out_o.fault_kind),
  .decoded_crc    (out_o.decoded_crc),
  .computed_crc   (out_o.computed_crc),
  .payload_length (out_o.payload_length)
);

FILE: tb/sv/crc32_frame_trailer_check_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the CRC-32 frame trailer check unit. It follows every beat on the byte and
// result channels, predicts each frame's result and compares it field by field.
// Depends on cftc_pkg and the channel interfaces in cftc_if.sv.
module crc32_frame_trailer_check_unit_checker import cftc_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  cftc_in_if   in_i,
  cftc_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [CrcW-1:0]  crc_run;
  logic [ByteW-1:0] tail_line [TailLen];
  int unsigned      frame_len;
  result_t          frame_results_q [$];
  result_t          oldest;

  function automatic logic [CrcW-1:0] crc_update(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int k = 0; k < ByteW; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [4:0] digit_of(logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  task automatic clear_frame();
    crc_run   = CrcInit;
    frame_len = 0;
    for (int i = 0; i < TailLen; i++) begin
      tail_line[i] = '0;
    end
  endtask

  task automatic fold_frame_byte(logic [ByteW-1:0] b, logic fin);
    result_t         r;
    logic [CrcW-1:0] digits;
    logic            bad_digit;
    logic [4:0]      d;
    if (frame_len >= TailLen) begin
      crc_run = crc_update(crc_run, tail_line[TailLen-1]);
    end
    for (int i = TailLen - 1; i > 0; i--) begin
      tail_line[i] = tail_line[i-1];
    end
    tail_line[0] = b;
    if (frame_len < MaxFrameBytes) begin
      frame_len++;
    end
    if (!fin) begin
      return;
    end
    r = '0;
    if (frame_len >= MaxFrameBytes) begin
      r.fault_kind = FAULT_TOO_LONG;
    end else if (frame_len < MinFrame) begin
      r.fault_kind = FAULT_CRC;
    end else begin
      r.computed_crc   = ~crc_run;
      r.payload_length = PlenW'(frame_len - TailLen);
      if (tail_line[TailLen-1] != StarChar) begin
        r.fault_kind = FAULT_CRC;
      end else begin
        digits    = '0;
        bad_digit = 1'b0;
        for (int i = HexDigits - 1; i >= 0; i--) begin
          d = digit_of(tail_line[i]);
          if (!d[4]) begin
            bad_digit = 1'b1;
          end
          digits = {digits[CrcW-5:0], d[3:0]};
        end
        if (bad_digit) begin
          r.fault_kind = FAULT_CRC;
        end else begin
          r.decoded_crc = digits;
          if (digits != r.computed_crc) begin
            r.fault_kind = FAULT_CRC;
          end
        end
      end
    end
    r.frame_valid = (r.fault_kind == FAULT_NONE);
    frame_results_q.push_back(r);
    clear_frame();
  endtask

  task automatic check_field(string name, logic [CrcW-1:0] want, logic [CrcW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      frame_results_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result beat with no frame outstanding");
          fail_count_o++;
        end else begin
          oldest = frame_results_q.pop_front();
          check_field("frame_valid", 32'(oldest.frame_valid), 32'(out_i.frame_valid));
          check_field("fault_kind", 32'(oldest.fault_kind), 32'(out_i.fault_kind));
          check_field("decoded_crc", oldest.decoded_crc, out_i.decoded_crc);
          check_field("computed_crc", oldest.computed_crc, out_i.computed_crc);
          check_field("payload_length", 32'(oldest.payload_length), 32'(out_i.payload_length));
        end
      end
      if (in_i.valid && in_i.ready) begin
        fold_frame_byte(in_i.data_byte, in_i.last_byte);
      end
    end
    pending_o = frame_results_q.size();
  end

endmodule

FILE: tb/sv/crc32_frame_trailer_check_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the CRC-32 frame trailer check unit: builds well-formed, corrupted
// and noise frames, drives them with random gaps and result stalls, and gives the verdict.
// Depends on cftc_pkg, the channel interfaces, the unit and its checker.
module crc32_frame_trailer_check_unit_tb;
  import cftc_pkg::*;

  localparam int unsigned FrameCap   = MaxFrameBytesDef;
  localparam int unsigned ItemTarget = 1950;
  localparam int unsigned MinFrames  = 60;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned NumKinds   = 7;

  typedef enum int unsigned {
    FR_GOOD, FR_BAD_CRC, FR_BAD_HEX, FR_NO_STAR, FR_SHORT, FR_NOISE, FR_LONG
  } frame_kind_e;

  logic             clk_i;
  logic             rst_ni;
  int               fail_count;
  int               pending;
  int unsigned      cycles;
  int unsigned      beats_sent;
  bit               byte_gaps_on;
  bit               quiet_tail;
  bit               long_hold_req;
  logic [ByteW-1:0] frame_bytes [$];
  logic [CrcW-1:0]  trailer_crc;

  cftc_in_if  byte_if ();
  cftc_out_if res_if ();

  crc32_frame_trailer_check_unit #(.MaxFrameBytes(FrameCap)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  crc32_frame_trailer_check_unit_checker #(.MaxFrameBytes(FrameCap)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (byte_if),
    .out_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [ByteW-1:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? ByteW'(8'h30 + nib) : ByteW'(8'h37 + nib);
  endfunction

  function automatic bit is_hex(logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic void append_trailer();
    logic [CrcW-1:0] c;
    c = CrcInit;
    foreach (frame_bytes[i]) begin
      c = c ^ CrcW'(frame_bytes[i]);
      repeat (ByteW) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    trailer_crc = ~c;
    frame_bytes.push_back(StarChar);
    for (int d = HexDigits - 1; d >= 0; d--) begin
      frame_bytes.push_back(hex_char(trailer_crc[4*d +: 4]));
    end
  endfunction

  function automatic void build_frame(frame_kind_e kind, int unsigned n);
    int unsigned      p;
    logic [ByteW-1:0] c;
    frame_bytes.delete();
    repeat (n) frame_bytes.push_back(ByteW'($urandom));
    if (kind == FR_NOISE) begin
      return;
    end
    append_trailer();
    p = $urandom_range(0, HexDigits - 1);
    case (kind)
      FR_BAD_CRC: begin
        frame_bytes[n+1+p] = hex_char(trailer_crc[4*(HexDigits-1-p) +: 4]
                                      ^ 4'($urandom_range(1, 15)));
      end
      FR_BAD_HEX: begin
        if ($urandom_range(0, 1) == 1) begin
          c = ByteW'(8'h61 + $urandom_range(0, 5));
        end else begin
          do c = ByteW'($urandom); while (is_hex(c));
        end
        frame_bytes[n+1+p] = c;
      end
      FR_NO_STAR: begin
        do c = ByteW'($urandom); while (c == StarChar);
        frame_bytes[n] = c;
      end
      default: ;
    endcase
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return FR_GOOD;
    if (r < 62) return FR_BAD_CRC;
    if (r < 74) return FR_BAD_HEX;
    if (r < 84) return FR_NO_STAR;
    if (r < 92) return FR_SHORT;
    return FR_NOISE;
  endfunction

  function automatic int unsigned pick_len(frame_kind_e kind);
    case (kind)
      FR_LONG:  return $urandom_range(FrameCap - TailLen, FrameCap - TailLen + 3);
      FR_NOISE: return $urandom_range(1, 40);
      FR_SHORT: return $urandom_range(0, MinFrame - TailLen - 1);
      default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(21, 48)
                                                    : $urandom_range(2, 20);
    endcase
  endfunction

  task automatic send_beat(input logic [ByteW-1:0] b, input logic fin);
    if (byte_gaps_on && $urandom_range(0, 3) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= fin;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("crc32_frame_trailer_check_unit verification failed");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    bit          stalls_on;
    hold_left = 0;
    stalls_on = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet_tail) begin
        stalls_on = 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        stalls_on = !stalls_on;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHold;
      end else if (hold_left == 0 && stalls_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    frame_kind_e kind;
    int unsigned frame_no;
    int unsigned n;
    rst_ni            = 1'b0;
    beats_sent        = 0;
    byte_gaps_on      = 1'b0;
    quiet_tail        = 1'b0;
    long_hold_req     = 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    frame_bytes = '{8'h00, 8'hFF};
    append_trailer();
    send_frame();
    build_frame(FR_SHORT, MinFrame - TailLen - 1);
    send_frame();
    build_frame(FR_NOISE, 1);
    send_frame();

    frame_no = 0;
    while (beats_sent < ItemTarget || frame_no < MinFrames) begin
      kind = (frame_no < NumKinds) ? frame_kind_e'(frame_no) : pick_kind();
      n    = pick_len(kind);
      if (frame_no == NumKinds) begin
        kind = FR_GOOD;
        n    = FrameCap - TailLen - 1;
      end
      quiet_tail   = beats_sent + 200 > ItemTarget;
      byte_gaps_on = !quiet_tail && $urandom_range(0, 2) != 0;
      if (frame_no == 12) begin
        long_hold_req = 1'b1;
        byte_gaps_on  = 1'b0;
      end
      if (frame_no == 25) begin
        byte_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      build_frame(kind, n);
      send_frame();
      frame_no++;
    end
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("crc32_frame_trailer_check_unit verification clean");
    end else begin
      $display("crc32_frame_trailer_check_unit verification failed");
    end
    $finish;
  end

endmodule
